@@ hdl/coordinate_line_parser_top_macros.svh @@
// Assertion macros shared by the checking code of the coordinate line parser.
`ifndef COORDINATE_LINE_PARSER_TOP_MACROS_SVH
`define COORDINATE_LINE_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define CLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("coordinate line parser check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define CLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("coordinate line parser check failed");

`endif

@@ hdl/clp_pkg.sv @@
package clp_pkg;

    // Default sizes.
    localparam int LINE_CAPACITY_DEF  = 64;
    localparam int OP_QUEUE_DEPTH_DEF = 4;
    localparam int RES_QUEUE_DEPTH    = 2;

    // Characters the parser reacts to.
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Value length limit and marker length.
    localparam logic [4:0] MAX_VALUE_LEN = 5'd15;
    localparam logic [1:0] MARKER_LEN    = 2'd3;

    // Magnitude limits of the conversion.
    localparam logic [35:0] MAG_CAP_WIDE = 36'h080000000;
    localparam logic [31:0] MAG_CAP      = 32'h80000000;
    localparam logic [31:0] POS_MAX      = 32'h7FFFFFFF;

    // Line status codes.
    localparam logic [1:0] STATUS_UPDATED   = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_DROPPED   = 2'd2;

    // Operation passed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_START,
        OP_CHAR,
        OP_TERM,
        OP_DROP
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] ch;
    } op_t;

    // Search and collect phase of one field.
    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_COLLECT,
        PH_DONE,
        PH_FAIL
    } phase_t;

    // Phase of the number conversion.
    typedef enum logic [1:0] {
        NUM_BLANKS,
        NUM_SIGNED,
        NUM_DIGITS,
        NUM_STOPPED
    } num_phase_t;

    // Status of one field as seen by the back end.
    typedef struct packed {
        phase_t phase;
        logic   has_len;
    } field_stat_t;

    // One result beat.
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [1:0]  status;
    } result_t;

endpackage

@@ hdl/clp_fifo.sv @@
module clp_fifo
    import clp_pkg::*;
#(
    parameter int WIDTH = 10,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Storage; entries carry no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/clp_front.sv @@
module clp_front
    import clp_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_beat,
    input  logic [7:0] rx_byte,
    output logic       op_push,
    output op_t        op_data
);

    localparam int CNT_W = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LINE_CAPACITY - 1);

    logic             in_line_reg;
    logic             in_line_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Classify each accepted byte and track line framing and length.
    always_comb
    begin
        in_line_next = in_line_reg;
        count_next   = count_reg;
        op_push      = 1'b0;
        op_data.kind = OP_CHAR;
        op_data.ch   = rx_byte;
        if (in_beat)
        begin
            if (!in_line_reg)
            begin
                if (rx_byte == CH_D)
                begin
                    in_line_next = 1'b1;
                    count_next   = CNT_W'(1);
                    op_push      = 1'b1;
                    op_data.kind = OP_START;
                end
            end
            else if (count_reg >= LAST_CNT)
            begin
                // The line has no room left: drop it.
                in_line_next = 1'b0;
                count_next   = '0;
                op_push      = 1'b1;
                op_data.kind = OP_DROP;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                op_push    = 1'b1;
                if (rx_byte == CH_LF || rx_byte == CH_CR)
                begin
                    in_line_next = 1'b0;
                    op_data.kind = OP_TERM;
                end
            end
        end
    end

    // Framing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_line_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            in_line_reg <= in_line_next;
            count_reg   <= count_next;
        end
    end

endmodule

@@ hdl/clp_field.sv @@
module clp_field
    import clp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        feed,
    input  logic [7:0]  ch,
    input  logic [7:0]  marker_ch,
    input  logic        use_comma,
    output field_stat_t stat,
    output logic [31:0] value
);

    logic [1:0]  prog_reg;
    logic [1:0]  prog_next;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [4:0]  len_reg;
    logic [4:0]  len_next;
    logic [31:0] accum_reg;
    logic [31:0] accum_next;
    logic        neg_reg;
    logic        neg_next;
    num_phase_t  nph_reg;
    num_phase_t  nph_next;

    logic [1:0]  prog_b;
    phase_t      phase_b;
    logic [4:0]  len_b;
    logic [31:0] accum_b;
    logic        neg_b;
    num_phase_t  nph_b;
    logic [7:0]  want;
    logic [1:0]  prog_adv;
    logic        is_digit;
    logic        is_blank;
    logic [35:0] scaled;
    logic [4:0]  len_inc;

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));

    // Marker search, value length check and atoi-style conversion.
    always_comb
    begin
        prog_b  = clear ? 2'd0 : prog_reg;
        phase_b = clear ? PH_SEARCH : phase_reg;
        len_b   = clear ? 5'd0 : len_reg;
        accum_b = clear ? 32'd0 : accum_reg;
        neg_b   = clear ? 1'b0 : neg_reg;
        nph_b   = clear ? NUM_BLANKS : nph_reg;

        prog_next  = prog_b;
        phase_next = phase_b;
        len_next   = len_b;
        accum_next = accum_b;
        neg_next   = neg_b;
        nph_next   = nph_b;

        want = (prog_b == 2'd0) ? CH_D : ((prog_b == 2'd1) ? marker_ch : CH_COLON);
        prog_adv = (ch == want) ? prog_b + 2'd1 : ((ch == CH_D) ? 2'd1 : 2'd0);
        scaled = ({4'd0, accum_b} << 3) + ({4'd0, accum_b} << 1) + {32'd0, ch[3:0]};
        len_inc = len_b + 5'd1;

        if (feed)
        begin
            case (phase_b)
                PH_SEARCH:
                begin
                    if (prog_adv == MARKER_LEN)
                    begin
                        prog_next  = 2'd0;
                        phase_next = PH_COLLECT;
                        len_next   = 5'd0;
                        accum_next = 32'd0;
                        neg_next   = 1'b0;
                        nph_next   = NUM_BLANKS;
                    end
                    else
                    begin
                        prog_next = prog_adv;
                    end
                end
                PH_COLLECT:
                begin
                    if (use_comma && ch == CH_COMMA)
                    begin
                        phase_next = (len_b != 5'd0) ? PH_DONE : PH_FAIL;
                    end
                    else
                    begin
                        len_next = len_inc;
                        if (len_inc > MAX_VALUE_LEN)
                        begin
                            phase_next = PH_FAIL;
                        end
                        else if (nph_b == NUM_STOPPED)
                        begin
                            nph_next = NUM_STOPPED;
                        end
                        else if (nph_b == NUM_BLANKS && !is_digit)
                        begin
                            if (!is_blank)
                            begin
                                if (ch == CH_PLUS || ch == CH_MINUS)
                                begin
                                    neg_next = (ch == CH_MINUS);
                                    nph_next = NUM_SIGNED;
                                end
                                else
                                begin
                                    nph_next = NUM_STOPPED;
                                end
                            end
                        end
                        else if (is_digit)
                        begin
                            accum_next = (scaled > MAG_CAP_WIDE) ? MAG_CAP : scaled[31:0];
                            nph_next   = NUM_DIGITS;
                        end
                        else
                        begin
                            nph_next = NUM_STOPPED;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_b;
                end
            endcase
        end
    end

    // Field state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg  <= 2'd0;
            phase_reg <= PH_SEARCH;
            len_reg   <= 5'd0;
            accum_reg <= 32'd0;
            neg_reg   <= 1'b0;
            nph_reg   <= NUM_BLANKS;
        end
        else
        begin
            prog_reg  <= prog_next;
            phase_reg <= phase_next;
            len_reg   <= len_next;
            accum_reg <= accum_next;
            neg_reg   <= neg_next;
            nph_reg   <= nph_next;
        end
    end

    // Signed value with the positive side clamped.
    assign value = neg_reg ? (32'd0 - accum_reg) : (accum_reg[31] ? POS_MAX : accum_reg);

    assign stat.phase   = phase_reg;
    assign stat.has_len = (len_reg != 5'd0);

endmodule

@@ hdl/clp_back.sv @@
module clp_back
    import clp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    op_valid,
    input  op_t     op_data,
    output logic    op_pop,
    input  logic    res_full,
    output logic    res_push,
    output result_t res_data
);

    field_stat_t x_stat;
    field_stat_t y_stat;
    logic [31:0] x_value;
    logic [31:0] y_value;
    logic        feed;
    logic        clear;
    logic        both_ok;
    logic [31:0] held_x_reg;
    logic [31:0] held_x_next;
    logic [31:0] held_y_reg;
    logic [31:0] held_y_next;

    // Take an operation only when a result beat would fit.
    assign op_pop = op_valid && !res_full;
    assign clear  = op_pop && (op_data.kind == OP_START);
    assign feed   = op_pop && (op_data.kind == OP_START || op_data.kind == OP_CHAR);

    // X value ends at a comma; Y value ends at the line terminator.
    clp_field u_x_field (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .feed      (feed),
        .ch        (op_data.ch),
        .marker_ch (CH_X),
        .use_comma (1'b1),
        .stat      (x_stat),
        .value     (x_value)
    );

    clp_field u_y_field (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .feed      (feed),
        .ch        (op_data.ch),
        .marker_ch (CH_Y),
        .use_comma (1'b0),
        .stat      (y_stat),
        .value     (y_value)
    );

    assign both_ok = (x_stat.phase == PH_DONE) && (y_stat.phase == PH_COLLECT) && y_stat.has_len;

    // Line end or drop: emit a result beat; a well-formed line also updates the held coordinates.
    always_comb
    begin
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        res_push        = 1'b0;
        res_data.status = STATUS_MALFORMED;
        if (op_pop)
        begin
            case (op_data.kind)
                OP_TERM:
                begin
                    res_push = 1'b1;
                    if (both_ok)
                    begin
                        held_x_next     = x_value;
                        held_y_next     = y_value;
                        res_data.status = STATUS_UPDATED;
                    end
                end
                OP_DROP:
                begin
                    res_push        = 1'b1;
                    res_data.status = STATUS_DROPPED;
                end
                default:
                begin
                    res_push = 1'b0;
                end
            endcase
        end
        res_data.x = held_x_next;
        res_data.y = held_y_next;
    end

    // Held coordinates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg <= 32'd0;
            held_y_reg <= 32'd0;
        end
        else
        begin
            held_x_reg <= held_x_next;
            held_y_reg <= held_y_next;
        end
    end

endmodule

@@ hdl/coordinate_line_parser_top.sv @@
// A terminating or overflowing byte is written into the operation queue when it is accepted;
// its result beat enters the result queue when the back end takes that operation.
// Throughput: one byte per cycle unless the operation queue is full; the back end takes one
// operation per cycle from the operation queue and stalls only while the result queue is full.
// Reset (rst_n low, asynchronous) clears framing, both field searches, the held
// coordinates to zero and both queues; no clearing pass follows.
module coordinate_line_parser_top
    import clp_pkg::*;
#(
    parameter int LINE_CAPACITY  = LINE_CAPACITY_DEF,
    parameter int OP_QUEUE_DEPTH = OP_QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] coord_x,
    output logic signed [31:0] coord_y,
    output logic [1:0]         line_status
);

    localparam int OP_W  = $bits(op_t);
    localparam int RES_W = $bits(result_t);

    logic             in_beat;
    logic             op_push;
    op_t              op_in;
    logic [OP_W-1:0]  op_out_raw;
    op_t              op_out;
    logic             op_empty;
    logic             op_pop;
    logic             res_full;
    logic             res_push;
    result_t          res_in;
    logic [RES_W-1:0] res_out_raw;
    result_t          res_out;

    assign in_beat = push && !full;

    // Front end: framing and classification.
    clp_front #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_beat (in_beat),
        .rx_byte (rx_byte),
        .op_push (op_push),
        .op_data (op_in)
    );

    // Queue between front and back end.
    clp_fifo #(
        .WIDTH (OP_W),
        .DEPTH (OP_QUEUE_DEPTH)
    ) u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_push),
        .wr_data (op_in),
        .rd_en   (op_pop),
        .rd_data (op_out_raw),
        .full    (full),
        .empty   (op_empty)
    );

    assign op_out = op_t'(op_out_raw);

    // Back end: field parsing and held coordinates.
    clp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (!op_empty),
        .op_data  (op_out),
        .op_pop   (op_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_in)
    );

    // Result queue facing the reader.
    clp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out_raw),
        .full    (res_full),
        .empty   (empty)
    );

    assign res_out     = result_t'(res_out_raw);
    assign coord_x     = res_out.x;
    assign coord_y     = res_out.y;
    assign line_status = res_out.status;

endmodule

@@ hdl/clp_checker.sv @@
`include "coordinate_line_parser_top_macros.svh"

module clp_checker
    import clp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] coord_x,
    input logic [31:0] coord_y,
    input logic [1:0]  line_status
);

    // A shown result never carries the unused status code.
    `CLP_ASSERT_NOW(a_status_code, clk, rst_n, !empty, line_status != 2'd3)

    // A result beat that is not taken stays in place unchanged.
    `CLP_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(coord_x) && $stable(coord_y) && $stable(line_status))

    // Right after reset the result queue is empty and the operation queue is not full.
    `CLP_ASSERT_NOW(a_reset_clean, clk, rst_n, $rose(rst_n), empty && !full)

    // The input side only fills up through an accepted byte.
    `CLP_ASSERT_NEXT(a_full_needs_push, clk, rst_n, !full && !push, !full)

endmodule

bind coordinate_line_parser_top clp_checker u_clp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .line_status (line_status)
);

@@ tb/sv/coordinate_line_parser_top_tb.sv @@
`timescale 1ns / 100ps

module coordinate_line_parser_top_tb;
    import clp_pkg::*;

    localparam int LINE_CAP    = LINE_CAPACITY_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_SLACK = 20;
    localparam int MAX_REPORTS = 10;

    // One field search as the parser tracks it within a line.
    typedef struct {
        logic [1:0]  progress;
        phase_t      phase;
        logic [4:0]  length;
        logic [31:0] mag;
        logic        neg;
        num_phase_t  nphase;
    } coord_field_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [7:0]        rx_byte = 8'h00;
    logic              empty;
    logic              pop = 1'b0;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [1:0]        line_status;

    // Predicted parser state.
    logic         line_open = 1'b0;
    int           line_len = 0;
    coord_field_t x_fld;
    coord_field_t y_fld;
    logic [31:0]  held_x = '0;
    logic [31:0]  held_y = '0;

    // Bytes waiting to be offered and line results waiting to come back.
    logic [7:0] bytes_to_send[$];
    result_t    expected_lines[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    int bytes_queued = 0;
    int lines_queued = 0;
    int beats_checked = 0;
    int full_stalls = 0;
    int mismatch_count = 0;
    int status_seen[3] = '{0, 0, 0};

    coordinate_line_parser_top #(
        .LINE_CAPACITY(LINE_CAP)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .rx_byte(rx_byte),
        .empty(empty),
        .pop(pop),
        .coord_x(coord_x),
        .coord_y(coord_y),
        .line_status(line_status)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Generous ceiling on the whole run.
    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------
    // Line parser prediction
    // ---------------------------------------------------------------

    function automatic bit blank_char(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic coord_field_t blank_field();
        coord_field_t f;
        f.progress = 2'd0;
        f.phase = PH_SEARCH;
        f.length = 5'd0;
        f.mag = '0;
        f.neg = 1'b0;
        f.nphase = NUM_BLANKS;
        return f;
    endfunction

    // One character of the atoi-style conversion, magnitude capped at 2^31.
    function automatic coord_field_t convert_step(coord_field_t f, logic [7:0] c);
        bit          is_digit;
        logic [63:0] wide;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (f.nphase == NUM_STOPPED)
            return f;
        if (f.nphase == NUM_BLANKS && !is_digit)
        begin
            if (blank_char(c))
                return f;
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                f.neg = (c == CH_MINUS);
                f.nphase = NUM_SIGNED;
            end
            else
            begin
                f.nphase = NUM_STOPPED;
            end
            return f;
        end
        if (is_digit)
        begin
            wide = 64'(f.mag) * 64'd10 + 64'(c - CH_ZERO);
            if (wide > 64'(MAG_CAP))
                wide = 64'(MAG_CAP);
            f.mag = wide[31:0];
            f.nphase = NUM_DIGITS;
        end
        else
        begin
            f.nphase = NUM_STOPPED;
        end
        return f;
    endfunction

    // Search for "D<tag>:"; a 'D' that breaks a partial match restarts it.
    function automatic coord_field_t marker_step(coord_field_t f, logic [7:0] c,
                                                 logic [7:0] tag);
        logic [7:0] want;
        want = (f.progress == 2'd0) ? CH_D : (f.progress == 2'd1) ? tag : CH_COLON;
        if (c == want)
            f.progress = f.progress + 2'd1;
        else
            f.progress = (c == CH_D) ? 2'd1 : 2'd0;
        if (f.progress == MARKER_LEN)
        begin
            f = blank_field();
            f.phase = PH_COLLECT;
        end
        return f;
    endfunction

    // One line character for a field; the X value alone ends at a comma.
    function automatic coord_field_t field_step(coord_field_t f, logic [7:0] c,
                                                logic [7:0] tag, bit comma_ends);
        case (f.phase)
            PH_SEARCH:
                f = marker_step(f, c, tag);
            PH_COLLECT:
                if (comma_ends && c == CH_COMMA)
                begin
                    f.phase = (f.length != 5'd0) ? PH_DONE : PH_FAIL;
                end
                else
                begin
                    f.length = f.length + 5'd1;
                    if (f.length > MAX_VALUE_LEN)
                        f.phase = PH_FAIL;
                    else
                        f = convert_step(f, c);
                end
            default:
                ;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] coord_value(coord_field_t f);
        if (f.neg)
            return 32'd0 - f.mag;
        return (f.mag > POS_MAX) ? POS_MAX : f.mag;
    endfunction

    // Feed one accepted byte; returns 1 when the byte finishes or drops a line.
    function automatic bit parse_line_byte(logic [7:0] c, output result_t res);
        res = '0;
        if (!line_open)
        begin
            if (c == CH_D)
            begin
                line_open = 1'b1;
                line_len = 1;
                x_fld = field_step(blank_field(), c, CH_X, 1'b1);
                y_fld = field_step(blank_field(), c, CH_Y, 1'b0);
            end
            return 1'b0;
        end
        if (line_len >= LINE_CAP - 1)
        begin
            line_open = 1'b0;
            line_len = 0;
            res.status = STATUS_DROPPED;
        end
        else
        begin
            line_len++;
            if (c != CH_LF && c != CH_CR)
            begin
                x_fld = field_step(x_fld, c, CH_X, 1'b1);
                y_fld = field_step(y_fld, c, CH_Y, 1'b0);
                return 1'b0;
            end
            line_open = 1'b0;
            if (x_fld.phase == PH_DONE && y_fld.phase == PH_COLLECT
                && y_fld.length != 5'd0)
            begin
                held_x = coord_value(x_fld);
                held_y = coord_value(y_fld);
                res.status = STATUS_UPDATED;
            end
            else
            begin
                res.status = STATUS_MALFORMED;
            end
        end
        res.x = held_x;
        res.y = held_y;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Byte driver, receiver and result checker
    // ---------------------------------------------------------------

    // Offer the next pending byte unless the sender idles this cycle.
    always @(posedge clk)
    begin : byte_driver
        result_t want;
        if (!rst_n)
        begin
            push <= 1'b0;
            rx_byte <= 8'h00;
        end
        else
        begin
            if (push && !full)
            begin
                if (parse_line_byte(rx_byte, want))
                    expected_lines.push_back(want);
            end
            if (push && full)
                full_stalls++;
            if (!push || !full)
            begin
                if (bytes_to_send.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    rx_byte <= bytes_to_send.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                    rx_byte <= 8'($urandom);
                end
            end
        end
    end

    // Long receiver hold-off, counted in its own process.
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_requests;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s: expected %0d, got %0d", $time, what,
                     $signed(want), $signed(got));
    endtask

    // Compare each popped result beat with the oldest predicted line result.
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                beats_checked++;
                if (expected_lines.size() == 0)
                begin
                    flag_mismatch("result beat with no line pending, status",
                                  32'd0, 32'(line_status));
                end
                else
                begin
                    want = expected_lines.pop_front();
                    status_seen[want.status]++;
                    if (coord_x !== want.x)
                        flag_mismatch("coord_x", want.x, coord_x);
                    if (coord_y !== want.y)
                        flag_mismatch("coord_y", want.y, coord_y);
                    if (line_status !== want.status)
                        flag_mismatch("line_status", 32'(want.status), 32'(line_status));
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Line generation
    // ---------------------------------------------------------------

    task automatic queue_byte(logic [7:0] b);
        bytes_to_send.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    task automatic queue_letters(int n);
        repeat (n) queue_byte(8'h61 + 8'($urandom_range(0, 25)));
    endtask

    task automatic queue_terminator();
        queue_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
    endtask

    // Printable junk; never a line terminator.
    task automatic queue_junk(int n);
        repeat (n) queue_byte(8'($urandom_range(8'h20, 8'h7E)));
    endtask

    // Bytes seen between lines; a 'D' here would open a line, so none is sent.
    task automatic queue_idle_noise(int n);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom);
            queue_byte((b == CH_D) ? CH_LF : b);
        end
    endtask

    // A blank that does not end the line.
    task automatic queue_blank();
        case ($urandom_range(0, 3))
            0: queue_byte(CH_SPACE);
            1: queue_byte(CH_TAB);
            2: queue_byte(8'h0B);
            default: queue_byte(8'h0C);
        endcase
    endtask

    task automatic queue_digits(int n);
        repeat (n) queue_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Random value text covering plain numbers, limits, saturation and bad lengths.
    task automatic queue_coord_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                repeat ($urandom_range(0, 2)) queue_blank();
                case ($urandom_range(0, 2))
                    0: queue_byte(CH_MINUS);
                    1: queue_byte(CH_PLUS);
                    default: ;
                endcase
                queue_digits($urandom_range(1, 10));
            end
            4:
                case ($urandom_range(0, 4))
                    0: queue_text("2147483647");
                    1: queue_text("-2147483648");
                    2: queue_text("2147483648");
                    3: queue_text("-2147483649");
                    default: queue_text("0");
                endcase
            5: queue_digits($urandom_range(11, 15));
            6: ;
            7: queue_digits($urandom_range(16, 20));
            8:
                case ($urandom_range(0, 3))
                    0: queue_byte(CH_PLUS);
                    1: queue_byte(CH_MINUS);
                    2: queue_text("abc");
                    default: queue_text(" -x");
                endcase
            default:
            begin
                queue_digits($urandom_range(1, 4));
                queue_junk(1);
                queue_digits($urandom_range(0, 4));
            end
        endcase
    endtask

    // Mostly well-formed lines with random values, the rest broken or noise.
    task automatic queue_random_line();
        int pick;
        pick = $urandom_range(0, 99);
        lines_queued++;
        if ($urandom_range(0, 3) == 0)
            queue_idle_noise($urandom_range(1, 4));
        if (pick < 60)
        begin
            queue_text("DX:");
            queue_coord_value();
            queue_byte(CH_COMMA);
            queue_text("DY:");
            queue_coord_value();
        end
        else if (pick < 68)
        begin
            queue_byte(CH_D);
            queue_junk($urandom_range(0, 6));
            queue_text("DX:");
            queue_coord_value();
            queue_byte(CH_COMMA);
            queue_junk($urandom_range(0, 4));
            queue_text("DY:");
            queue_coord_value();
        end
        else if (pick < 76)
        begin
            // X marker inside the Y value text.
            queue_text("DY:");
            queue_coord_value();
            queue_text("DX:");
            queue_coord_value();
            queue_byte(CH_COMMA);
        end
        else if (pick < 82)
        begin
            case ($urandom_range(0, 2))
                0: queue_text("DX:");
                1: queue_text("DY:");
                default:
                begin
                    queue_text("DX:");
                    queue_coord_value();
                    queue_text("DY:");
                end
            endcase
            queue_coord_value();
        end
        else if (pick < 88)
        begin
            // Any byte values inside a line, terminators and zero included.
            queue_byte(CH_D);
            repeat ($urandom_range(1, 20)) queue_byte(8'($urandom));
        end
        else if (pick < 92)
        begin
            queue_byte(CH_D);
            queue_letters($urandom_range(58, 66));
        end
        else
        begin
            queue_text("DX:");
            queue_coord_value();
            queue_text(",DY:");
            queue_coord_value();
            queue_terminator();
            queue_idle_noise($urandom_range(1, 3));
        end
        queue_terminator();
    endtask

    task automatic wait_bytes_sent();
        while (bytes_to_send.size() != 0 || push)
            @(negedge clk);
    endtask

    task automatic wait_results_back();
        while (expected_lines.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random_phase(int idle_pct, int stall_pct, int nbytes);
        int stop_at;
        @(negedge clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = bytes_queued + nbytes;
        while (bytes_queued < stop_at)
            queue_random_line();
        wait_bytes_sent();
    endtask

    // ---------------------------------------------------------------
    // Stimulus sequence
    // ---------------------------------------------------------------

    initial
    begin : stimulus_control
        @(posedge rst_n);
        @(negedge clk);

        // Directed lines: extremes, signs, blanks, every status and edge case.
        queue_text("abc\r\nDX:12,DY:-34\n");
        queue_text("DX:2147483647,DY:-2147483648\r");
        queue_text("DX:99999999999,DY:+99999999999\n");
        queue_text("DX: \t\013\014-7,DY:  +0\n");
        queue_text("DX:-0,DY:-2147483649\r");
        queue_text("DX:,DY:5\n");
        queue_text("DX:5,DY:\n");
        queue_text("DX:5 DY:6\n");
        queue_text("DX:1234567890123456,DY:1\n");
        queue_text("DX:123456789012345,DY:123456789012345\n");
        queue_text("DX:abc,DY:-\n");
        queue_text("DY:7DX:8,\n");
        queue_text("DDX:3,x DX:9,DY:4\r");
        queue_text("DX:4,DY:5");
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CH_LF);
        // Longest line that still ends normally, then one byte too long.
        queue_byte(CH_D);
        queue_letters(LINE_CAP - 3);
        queue_byte(CH_LF);
        queue_byte(CH_D);
        queue_letters(LINE_CAP - 2);
        queue_byte(CH_CR);
        // Overflow on a 'D', and overflow followed by a good line.
        queue_byte(CH_D);
        queue_letters(LINE_CAP - 2);
        queue_text("DX:2,DY:3\n");
        queue_byte(CH_D);
        queue_letters(LINE_CAP + 6);
        queue_text("DX:-1,DY:1\n");
        lines_queued += 21;
        wait_bytes_sent();

        run_random_phase(0, 0, 110);
        run_random_phase(49, 0, 110);
        run_random_phase(0, 49, 110);
        run_random_phase(20, 20, 110);

        // Receiver holds off while short lines keep coming, so the input backs up.
        @(negedge clk);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests++;
        repeat (40)
        begin
            lines_queued++;
            if ($urandom_range(0, 3) == 0)
            begin
                queue_byte(CH_D);
            end
            else
            begin
                queue_text("DX:");
                queue_digits(1);
                queue_text(",DY:");
                queue_digits(1);
            end
            queue_terminator();
        end
        wait_bytes_sent();

        // Sender pauses until every line result is back.
        wait_results_back();
        run_random_phase(0, 0, 110);

        @(negedge clk);
        recv_stall_pct = 0;
        wait_results_back();
        repeat (DRAIN_SLACK) @(posedge clk);
        @(negedge clk);
        if (expected_lines.size() != 0)
            flag_mismatch("line results never delivered", 32'd0,
                          32'(expected_lines.size()));

        $display("Sent %0d bytes in %0d lines under mixed sender and receiver gaps,",
                 bytes_queued, lines_queued);
        $display("checked %0d beats (%0d updated, %0d malformed, %0d dropped), %0d full stalls.",
                 beats_checked, status_seen[STATUS_UPDATED], status_seen[STATUS_MALFORMED],
                 status_seen[STATUS_DROPPED], full_stalls);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/clp_pkg.sv
hdl/clp_fifo.sv
hdl/clp_front.sv
hdl/clp_field.sv
hdl/clp_back.sv
hdl/coordinate_line_parser_top.sv
hdl/clp_checker.sv
tb/sv/coordinate_line_parser_top_tb.sv
